@@ src/rlewd_pkg.sv @@
// Package for the run-length word line decompressor.
// Holds field widths, marker masks, register indexes and the parse phase type.
// Depends on nothing; imported by the top level and its checker.
`default_nettype none

package rlewd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned LineW    = 11;
  localparam int unsigned PosW     = 10;
  localparam int unsigned RunW     = 16;
  localparam int unsigned LitW     = 12;
  localparam int unsigned LitShift = 16;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [WordW-1:0] MarkMask = 32'hF000_0000;
  localparam logic [LineW-1:0] MaxLine  = 11'd1024;
  localparam logic [LineW-1:0] LineRst  = 11'd60;

  // Register index, taken from paddr above the byte offset.
  localparam logic RegLineWords = 1'b0;

  // Request kinds on the input channel.
  localparam logic ReqData = 1'b0;
  localparam logic ReqPull = 1'b1;

  typedef enum logic [2:0] {
    PH_MARKER  = 3'b001,
    PH_VALUE   = 3'b010,
    PH_LITERAL = 3'b100
  } phase_e;

endpackage

`default_nettype wire

@@ src/rle_word_line_decompressor.sv @@
// Top level of the run-length word line decompressor.
// Parses marker, run value and literal words, expands runs on pulls, marks line ends.
// Depends on rlewd_pkg.
//
// Usage: the input channel carries one word per handshake: req_type_i selects
// between a compressed stream word (data_word_i) and a pull of the next run word.
// Every accepted input word yields exactly one result word on the output channel:
// word_valid_o tells whether out_word_o carries a decompressed word, line_end_o
// marks the last word of a display line, run_pending_o says that run words are
// still waiting to be pulled, and format_error_o flags a dropped bad marker or a
// data word offered while a run was pending.
// The result of an accepted word is registered and shown from the next cycle on.
// Throughput is one word per clock while the receiver takes results; the whole
// decode step sits between the parse state registers and the result register.
// When the receiver stalls, the result register holds its word and in_ready_o
// drops until the result is taken; a result taken in the same cycle frees the
// register, so the stream keeps moving at full rate.
// The APB port holds one register, line_words, at byte address 0; a write keeps
// its low 11 bits, saturated to 1024. Reset clears the parser to expect a marker,
// zeroes the counters and the line position, and sets line_words to 60.
`default_nettype none

module rle_word_line_decompressor
  import rlewd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic [WordW-1:0]  data_word_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   word_valid_o,
  output logic [WordW-1:0]       out_word_o,
  output logic                   line_end_o,
  output logic                   run_pending_o,
  output logic                   format_error_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready
);

  // Parse state.
  phase_e            phase_q, phase_d;
  logic [RunW-1:0]   run_left_q, run_left_d;
  logic [LitW-1:0]   lit_left_q, lit_left_d;
  logic [WordW-1:0]  held_q, held_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LineW-1:0]  line_words_q, line_words_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              wvalid_q, wvalid_d;
  logic [WordW-1:0]  oword_q, oword_d;
  logic              lend_q, lend_d;
  logic              pend_q, pend_d;
  logic              err_q, err_d;

  logic              in_fire;
  logic              cfg_wr;
  logic              pending;
  logic              is_last;
  logic [LineW-1:0]  pos_inc;
  logic [LineW-1:0]  wdata_line;

  // The result register may be refilled in the cycle it is emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Run words may only be pulled once the run value has been taken.
  assign pending = (run_left_q != '0) && (phase_q != PH_VALUE);

  // Line counter: the position after this word reaching line_words ends the line.
  // A line length of zero therefore ends every line.
  assign pos_inc = {1'b0, pos_q} + LineW'(1);
  assign is_last = pos_inc >= line_words_q;

  always_comb begin
    phase_d    = phase_q;
    run_left_d = run_left_q;
    lit_left_d = lit_left_q;
    held_d     = held_q;
    pos_d      = pos_q;
    wvalid_d   = 1'b0;
    oword_d    = '0;
    lend_d     = 1'b0;
    err_d      = 1'b0;

    priority if (req_type_i == ReqPull) begin
      if (pending) begin
        wvalid_d   = 1'b1;
        oword_d    = held_q;
        lend_d     = is_last;
        pos_d      = is_last ? '0 : pos_inc[PosW-1:0];
        run_left_d = run_left_q - RunW'(1);
      end
    end else if (pending) begin
      // Data offered while run words are still owed: drop it.
      err_d = 1'b1;
    end else if (phase_q == PH_VALUE) begin
      held_d  = data_word_i;
      phase_d = (lit_left_q != '0) ? PH_LITERAL : PH_MARKER;
    end else if (phase_q == PH_LITERAL && lit_left_q != '0) begin
      wvalid_d   = 1'b1;
      oword_d    = data_word_i;
      lend_d     = is_last;
      pos_d      = is_last ? '0 : pos_inc[PosW-1:0];
      lit_left_d = lit_left_q - LitW'(1);
      if (lit_left_q == LitW'(1)) begin
        phase_d = PH_MARKER;
      end
    end else begin
      // Expecting a marker; a word without the marker nibble is dropped.
      phase_d = PH_MARKER;
      if ((data_word_i & MarkMask) != MarkMask) begin
        err_d = 1'b1;
      end else begin
        run_left_d = data_word_i[RunW-1:0];
        lit_left_d = data_word_i[LitShift +: LitW];
        phase_d    = PH_VALUE;
      end
    end

    pend_d = (run_left_d != '0) && (phase_d != PH_VALUE);
  end

  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  // Configuration: one register, saturated to the longest line.
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[AddrW-1] == RegLineWords);
  assign wdata_line = (pwdata[LineW-1:0] > MaxLine) ? MaxLine : pwdata[LineW-1:0];
  assign line_words_d = cfg_wr ? wdata_line : line_words_q;

  always_comb begin
    unique case (paddr[AddrW-1])
      RegLineWords: prdata = {{(PdataW-LineW){1'b0}}, line_words_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MARKER;
      run_left_q   <= '0;
      lit_left_q   <= '0;
      held_q       <= '0;
      pos_q        <= '0;
      line_words_q <= LineRst;
      out_valid_q  <= 1'b0;
    end else begin
      line_words_q <= line_words_d;
      out_valid_q  <= out_valid_d;
      if (in_fire) begin
        phase_q    <= phase_d;
        run_left_q <= run_left_d;
        lit_left_q <= lit_left_d;
        held_q     <= held_d;
        pos_q      <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wvalid_q <= wvalid_d;
      oword_q  <= oword_d;
      lend_q   <= lend_d;
      pend_q   <= pend_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_valid_o   = wvalid_q;
  assign out_word_o     = oword_q;
  assign line_end_o     = lend_q;
  assign run_pending_o  = pend_q;
  assign format_error_o = err_q;

endmodule

`default_nettype wire

@@ src/rlewd_checker.sv @@
// Port-level checker for the run-length word line decompressor.
// Watches the top level's ports only; attached by the bind at the end of this file.
// Depends on rlewd_pkg.
`default_nettype none

module rlewd_checker
  import rlewd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              req_type_i,
  input wire logic [WordW-1:0]  data_word_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              word_valid_o,
  input wire logic [WordW-1:0]  out_word_o,
  input wire logic              line_end_o,
  input wire logic              run_pending_o,
  input wire logic              format_error_o,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [AddrW-1:0]  paddr,
  input wire logic [PdataW-1:0] pwdata,
  input wire logic [PdataW-1:0] prdata,
  input wire logic              pready
);

  // A stalled result blocks the input side.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while a stalled result was held");

  // A stalled result keeps its word.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o)
                                    && $stable(word_valid_o))
    else $error("stalled result changed");

  // A result without a word carries no word and no line end.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_valid_o |-> out_word_o == '0 && !line_end_o)
    else $error("empty result carries data");

  // A dropped word never also produces output.
  a_error_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_error_o |-> !word_valid_o)
    else $error("error result also carries a word");

  // The line length register never reads back above the longest line.
  a_line_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[AddrW-1] == RegLineWords
    |=> paddr[AddrW-1] != RegLineWords || prdata <= PdataW'(MaxLine))
    else $error("line length above maximum");

endmodule

bind rle_word_line_decompressor rlewd_checker u_rlewd_checker (.*);

`default_nettype wire

@@ verif/rle_word_line_decompressor_tb.sv @@
// Testbench for the run-length word line decompressor: a directed table, then random groups.
// Runs include line length changes and one group with the largest counts. Each result word
// is checked against the model or a pinned result. Depends on rlewd_pkg and the top level.
`default_nettype none

module rle_word_line_decompressor_tb;
  import rlewd_pkg::*;

  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int MaxReports    = 10;
  localparam int PhaseItems    = 110;
  localparam int LongRunPulls  = 300;
  localparam int ShortLinePulls = 40;
  localparam logic [AddrW-1:0] LineWordsAddr = AddrW'({RegLineWords, 2'b00});

  typedef struct packed {
    logic             word_valid;
    logic [WordW-1:0] out_word;
    logic             line_end;
    logic             run_pending;
    logic             format_error;
  } line_result_t;

  // One directed word. When pinned is set, the typed result is checked instead of the model's.
  typedef struct packed {
    logic             req;
    logic [WordW-1:0] word;
    logic             pinned;
    line_result_t     want;
  } stim_row_t;

  localparam line_result_t NoWord   = '0;
  localparam line_result_t Dropped  = '{1'b0, 32'h0, 1'b0, 1'b0, 1'b1};
  localparam line_result_t RunArmed = '{1'b0, 32'h0, 1'b0, 1'b1, 1'b0};

  // Line length is 60 from reset throughout this table.
  localparam int DirectedCount = 21;
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{ReqPull, 32'h0000_0000, 1'b1, NoWord},    // pull with no run pending
    '{ReqData, 32'h0000_0000, 1'b1, Dropped},   // bad marker, all zero
    '{ReqData, 32'hEFFF_FFFF, 1'b1, Dropped},   // bad marker, nibble just below 0xF
    '{ReqData, 32'hF000_0000, 1'b1, NoWord},    // empty group
    '{ReqPull, 32'hFFFF_FFFF, 1'b1, NoWord},    // pull before the run value
    '{ReqData, 32'hFFFF_FFFF, 1'b1, NoWord},    // empty group still eats its value word
    '{ReqData, 32'hF002_0003, 1'b1, NoWord},    // two literals, run of three
    '{ReqPull, 32'h0000_0000, 1'b1, NoWord},    // pull before the run value again
    '{ReqData, 32'hA5A5_5A5A, 1'b1, RunArmed},  // run value arms the run
    '{ReqData, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},  // data during run
    '{ReqPull, 32'h0000_0000, 1'b1, '{1'b1, 32'hA5A5_5A5A, 1'b0, 1'b1, 1'b0}},
    '{ReqPull, 32'h0000_0000, 1'b0, NoWord},
    '{ReqPull, 32'h0000_0000, 1'b0, NoWord},    // last run word
    '{ReqPull, 32'h0000_0000, 1'b0, NoWord},    // run exhausted
    '{ReqData, 32'h0000_0000, 1'b0, NoWord},    // literal, all zero
    '{ReqData, 32'hFFFF_FFFF, 1'b0, NoWord},    // literal, all one
    '{ReqData, 32'hF001_0000, 1'b0, NoWord},    // one literal, no run
    '{ReqData, 32'h5A5A_A5A5, 1'b0, NoWord},
    '{ReqPull, 32'h0000_0000, 1'b0, NoWord},    // pull in literal phase
    '{ReqData, 32'hF000_0001, 1'b0, NoWord},    // looks like a marker but is a literal
    '{ReqData, 32'h7FFF_FFFF, 1'b1, Dropped}    // bad marker
  };

  // Line settings for the random phases: extremes, zero, saturation and masking first.
  localparam int SettingCount = 7;
  localparam logic [PdataW-1:0] LineSettings [SettingCount] = '{
    32'd1, 32'd1024, 32'd0, 32'd2047, 32'hFFFF_F803, 32'd7, 32'd60
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              req_type_i     = ReqData;
  logic [WordW-1:0]  data_word_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              word_valid_o;
  logic [WordW-1:0]  out_word_o;
  logic              line_end_o;
  logic              run_pending_o;
  logic              format_error_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [AddrW-1:0]  paddr          = '0;
  logic [PdataW-1:0] pwdata         = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  rle_word_line_decompressor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .data_word_i   (data_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_valid_o  (word_valid_o),
    .out_word_o    (out_word_o),
    .line_end_o    (line_end_o),
    .run_pending_o (run_pending_o),
    .format_error_o(format_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder model state, kept in step with every accepted input word.
  phase_e           dec_phase     = PH_MARKER;
  logic [RunW-1:0]  dec_run_left  = '0;
  logic [LitW-1:0]  dec_lit_left  = '0;
  logic [WordW-1:0] dec_run_value = '0;
  logic [PosW-1:0]  dec_line_pos  = '0;
  logic [LineW-1:0] line_len      = LineRst;

  line_result_t decoded_q [$];
  int  mismatches   = 0;
  int  items_done   = 0;
  bit  sender_calm  = 1'b0;
  bit  recv_calm    = 1'b0;
  bit  hold_off_req = 1'b0;

  function automatic bit run_armed();
    return dec_run_left != '0 && dec_phase != PH_VALUE;
  endfunction

  // Advances the line position for one emitted word and says whether it closed the line.
  // A line length of zero behaves as one, since the compare always succeeds.
  function automatic logic close_line();
    if (int'(dec_line_pos) + 1 >= int'(line_len)) begin
      dec_line_pos = '0;
      return 1'b1;
    end
    dec_line_pos = dec_line_pos + 1'b1;
    return 1'b0;
  endfunction

  function automatic line_result_t decode_word(input logic req, input logic [WordW-1:0] word);
    line_result_t res;
    res = '0;
    if (req == ReqPull) begin
      if (run_armed()) begin
        res.word_valid = 1'b1;
        res.out_word   = dec_run_value;
        res.line_end   = close_line();
        dec_run_left   = dec_run_left - 1'b1;
      end
    end else if (run_armed()) begin
      // A data word offered while the run is still being pulled is dropped.
      res.format_error = 1'b1;
    end else if (dec_phase == PH_VALUE) begin
      dec_run_value = word;
      dec_phase     = (dec_lit_left != '0) ? PH_LITERAL : PH_MARKER;
    end else if (dec_phase == PH_LITERAL && dec_lit_left != '0) begin
      res.word_valid = 1'b1;
      res.out_word   = word;
      res.line_end   = close_line();
      dec_lit_left   = dec_lit_left - 1'b1;
      if (dec_lit_left == '0) begin
        dec_phase = PH_MARKER;
      end
    end else begin
      dec_phase = PH_MARKER;
      if ((word & MarkMask) != MarkMask) begin
        res.format_error = 1'b1;
      end else begin
        dec_run_left = word[RunW-1:0];
        dec_lit_left = word[LitShift +: LitW];
        dec_phase    = PH_VALUE;
      end
    end
    res.run_pending = run_armed();
    return res;
  endfunction

  // Mostly no gap, else short gaps and a few long ones; none at all in calm stretches.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Offers one word and, once it is taken, queues the result it must produce.
  task automatic send_word(input logic req, input logic [WordW-1:0] word,
                           input logic pinned = 1'b0, input line_result_t want = '0);
    int gap;
    line_result_t pred;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_word_i <= word;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pred = decode_word(req, word);
    decoded_q.push_back(pinned ? want : pred);
    items_done++;
  endtask

  // A marker, its run value, the run pulled out word by word, then the literals.
  // With drop_pct above zero the group also carries early pulls, dropped data and extra pulls.
  task automatic send_group(input int lit_n, input int run_n, input int drop_pct);
    int i;
    send_word(ReqData, {4'hF, 12'(lit_n), 16'(run_n)});
    if (drop_pct > 0 && $urandom_range(0, 2) == 0) begin
      send_word(ReqPull, $urandom);
    end
    send_word(ReqData, $urandom);
    for (i = 0; i < run_n; i++) begin
      if (drop_pct > 0 && $urandom_range(0, 99) < drop_pct) begin
        send_word(ReqData, $urandom);
      end
      send_word(ReqPull, $urandom);
    end
    if (drop_pct > 0 && $urandom_range(0, 2) == 0) begin
      send_word(ReqPull, $urandom);
    end
    for (i = 0; i < lit_n; i++) begin
      send_word(ReqData, $urandom);
    end
  endtask

  task automatic run_random_items(input int count);
    int target;
    int r;
    int lit_n;
    int run_n;
    target = items_done + count;
    while (items_done < target) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      recv_calm   = ($urandom_range(0, 3) == 0);
      lit_n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
      run_n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 80) : $urandom_range(0, 6);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_group(lit_n, run_n, 0);
      end else if (r < 90) begin
        send_group(lit_n, run_n, 15);
      end else if (r < 95) begin
        send_word(ReqPull, $urandom);
      end else begin
        // Noise between groups: a marker with a wrong top nibble.
        send_word(ReqData, {4'($urandom_range(0, 14)), 28'($urandom)});
      end
    end
  endtask

  task automatic apb_xfer(input logic wr, input logic [PdataW-1:0] wdata,
                          output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LineWordsAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_line_len();
    logic [PdataW-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== PdataW'(line_len)) begin
      flag_error($sformatf("line_words read back %0d, want %0d", rd, line_len));
    end
  endtask

  // The line length changes only once every queued word has come back.
  task automatic program_line_len(input logic [PdataW-1:0] value);
    logic [PdataW-1:0] rd;
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    apb_xfer(1'b1, value, rd);
    line_len = (value[LineW-1:0] > MaxLine) ? MaxLine : value[LineW-1:0];
    @(posedge clk_i);
    check_line_len();
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin : receiver
    int stall;
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        stall = pick_gap(recv_calm);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    line_result_t got;
    line_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got = '{word_valid_o, out_word_o, line_end_o, run_pending_o, format_error_o};
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected result valid=%b word=%h end=%b pend=%b err=%b",
                             got.word_valid, got.out_word, got.line_end,
                             got.run_pending, got.format_error));
      end else begin
        want = decoded_q.pop_front();
        if (got.word_valid !== want.word_valid || got.out_word !== want.out_word ||
            got.line_end !== want.line_end || got.run_pending !== want.run_pending ||
            got.format_error !== want.format_error) begin
          flag_error($sformatf(
              "want valid=%b word=%h end=%b pend=%b err=%b, got %b %h %b %b %b",
              want.word_valid, want.out_word, want.line_end, want.run_pending,
              want.format_error, got.word_valid, got.out_word, got.line_end,
              got.run_pending, got.format_error));
        end
      end
    end
  end

  // Ends the run when no word moves on either channel or the register port for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
          (psel && penable && pready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("rle_word_line_decompressor regression: fail");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_line_len();

    for (i = 0; i < DirectedCount; i++) begin
      send_word(DirectedRows[i].req, DirectedRows[i].word,
                DirectedRows[i].pinned, DirectedRows[i].want);
    end

    // Random phases, each under its own line length; the line position carries over.
    for (i = 0; i < SettingCount + 2; i++) begin
      if (i < SettingCount) begin
        program_line_len(LineSettings[i]);
      end else if (i == SettingCount) begin
        program_line_len($urandom);
      end else begin
        program_line_len($urandom_range(1, 1024));
      end
      if (i == 3) begin
        hold_off_req = 1'b1;
      end
      run_random_items(PhaseItems);
    end

    // One group with every count bit set, on the longest line. Only the first part of its
    // run is pulled, so the run is still pending when the test ends.
    program_line_len(32'd1024);
    sender_calm = 1'b0;
    recv_calm   = 1'b0;
    send_word(ReqData, 32'hFFFF_FFFF);
    send_word(ReqData, $urandom);
    for (i = 0; i < LongRunPulls; i++) begin
      send_word(ReqPull, $urandom);
    end

    // Shorten the line while the position normally sits past the new end, then keep
    // pulling, with some data words dropped along the way.
    program_line_len(32'd3);
    for (i = 0; i < ShortLinePulls; i++) begin
      send_word(($urandom_range(0, 4) == 0) ? ReqData : ReqPull, $urandom);
    end

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("rle_word_line_decompressor regression: pass");
    end else begin
      $display("rle_word_line_decompressor regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
